// File: hdl/b64d_pkg.sv
package b64d_pkg;

    // One character of base64 text as it arrives on the input channel.
    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } in_item_t;

    // One result as it leaves on the output channel.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       message_done;
        logic       bad_char;
    } out_item_t;

    localparam int unsigned MaxResults = 3;

    // The results caused by one character, with their count (0 to 3).
    typedef struct packed {
        logic [1:0]                      count;
        out_item_t [MaxResults-1:0]      res;
    } result_group_t;

    localparam logic [7:0] PadChar = 8'h3D;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    // Maps a character of the standard alphabet to its six-bit value.
    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            s.value = 6'(ch - 8'h41);
        end
        else if (ch >= 8'h61 && ch <= 8'h7A) begin
            s.value = 6'(ch - 8'h61 + 8'd26);
        end
        else if (ch >= 8'h30 && ch <= 8'h39) begin
            s.value = 6'(ch - 8'h30 + 8'd52);
        end
        else if (ch == 8'h2B) begin
            s.value = 6'd62;
        end
        else if (ch == 8'h2F) begin
            s.value = 6'd63;
        end
        else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

// File: hdl/b64d_decode.sv
module b64d_decode
    import b64d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  in_item_t      item,
    output result_group_t group
);

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  count_reg, count_next;
    logic        pad_reg, pad_next;
    logic        abort_reg, abort_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
            pad_reg   <= 1'b0;
            abort_reg <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            pad_reg   <= pad_next;
            abort_reg <= abort_next;
        end
    end

    always_comb
    begin
        sextet_t     sx;
        logic        bad_hit;
        logic [23:0] grp;
        logic [1:0]  n;

        sx         = sextet_of(item.text_char);
        bad_hit    = 1'b0;
        grp        = {acc_reg, sx.value};
        n          = 2'd0;
        group      = '0;
        acc_next   = acc_reg;
        count_next = count_reg;
        pad_next   = pad_reg;
        abort_next = abort_reg;

        if (!abort_reg && !pad_reg)
        begin
            if (item.text_char == PadChar)
            begin
                pad_next = 1'b1;
            end
            else if (!sx.valid)
            begin
                bad_hit    = 1'b1;
                abort_next = 1'b1;
                group.res[0] = '{data_byte: 8'd0, has_byte: 1'b0,
                                 message_done: item.end_of_text, bad_char: 1'b1};
                n = 2'd1;
            end
            else if (count_reg == 2'd3)
            begin
                group.res[0] = '{data_byte: grp[23:16], has_byte: 1'b1,
                                 message_done: 1'b0, bad_char: 1'b0};
                group.res[1] = '{data_byte: grp[15:8], has_byte: 1'b1,
                                 message_done: 1'b0, bad_char: 1'b0};
                group.res[2] = '{data_byte: grp[7:0], has_byte: 1'b1,
                                 message_done: 1'b0, bad_char: 1'b0};
                n          = 2'd3;
                acc_next   = '0;
                count_next = 2'd0;
            end
            else
            begin
                acc_next   = {acc_reg[11:0], sx.value};
                count_next = count_reg + 2'd1;
            end
        end

        if (item.end_of_text && !bad_hit)
        begin
            // Flush a partial group: n sextets give n-1 bytes.
            if (!abort_next)
            begin
                if (count_next == 2'd3)
                begin
                    group.res[0] = '{data_byte: acc_next[17:10], has_byte: 1'b1,
                                     message_done: 1'b0, bad_char: 1'b0};
                    group.res[1] = '{data_byte: acc_next[9:2], has_byte: 1'b1,
                                     message_done: 1'b0, bad_char: 1'b0};
                    n = 2'd2;
                end
                else if (count_next == 2'd2)
                begin
                    group.res[0] = '{data_byte: acc_next[11:4], has_byte: 1'b1,
                                     message_done: 1'b0, bad_char: 1'b0};
                    n = 2'd1;
                end
            end
            case (n)
                2'd1: group.res[0].message_done = 1'b1;
                2'd2: group.res[1].message_done = 1'b1;
                2'd3: group.res[2].message_done = 1'b1;
                default:
                begin
                    group.res[0] = '{data_byte: 8'd0, has_byte: 1'b0,
                                     message_done: 1'b1, bad_char: abort_next};
                    n = 2'd1;
                end
            endcase
        end

        if (item.end_of_text)
        begin
            acc_next   = '0;
            count_next = 2'd0;
            pad_next   = 1'b0;
            abort_next = 1'b0;
        end

        group.count = n;
    end

endmodule

// File: hdl/b64d_serializer.sv
module b64d_serializer
    import b64d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  result_group_t group,
    output logic          load_ready,
    output logic          result_valid,
    input  logic          result_stall,
    output out_item_t     result_item
);

    logic [1:0]                 count_reg, count_next;
    logic [1:0]                 idx_reg, idx_next;
    out_item_t [MaxResults-1:0] res_reg;
    logic                       taken;
    logic                       last;

    assign result_valid = (count_reg != 2'd0);
    assign taken        = result_valid && !result_stall;
    assign last         = (idx_reg == count_reg - 2'd1);
    assign load_ready   = !result_valid || (taken && last);

    always_comb
    begin
        case (idx_reg)
            2'd0:    result_item = res_reg[0];
            2'd1:    result_item = res_reg[1];
            2'd2:    result_item = res_reg[2];
            default: result_item = res_reg[0];
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (taken)
        begin
            if (last)
            begin
                count_next = 2'd0;
                idx_next   = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (load)
        begin
            count_next = group.count;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= group.res;
        end
    end

endmodule

// File: hdl/base64_stream_decoder_unit.sv
// Flow: a character taken into the input register moves on to the output stage when that
// stage is free; its results then follow one per cycle while result_stall is low.
// Throughput: one character per cycle while result_stall is low, but a character with
// two or three results (a full group gives three) holds the next back while they drain.
// Reset: rst_n is asynchronous and active low; it empties the input and output registers
// and clears the sextet accumulator, count, padding and abort flags.
module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      text_valid,
    output logic      text_stall,
    input  in_item_t  text_item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_item
);

    // The input register holds one request. It may take a new request whenever it is
    // empty or its current one moves on to the decoder in the same cycle, so one request
    // can wait here while earlier results are still draining from the output.
    logic          in_valid_reg;
    in_item_t      in_item_reg;
    logic          load_ready;
    logic          advance;
    logic          text_take;
    result_group_t group;

    assign advance    = in_valid_reg && load_ready;
    assign text_stall = in_valid_reg && !load_ready;
    assign text_take  = text_valid && !text_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            in_item_reg <= text_item;
        end
    end

    // The decoder works out, in one pass, every result the held character causes and
    // the decoder state it leaves behind. The state is committed only when the
    // character moves on, which happens when the output stage can take its results.
    b64d_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .group   (group)
    );

    // The output stage stores up to three results and presents them one at a time.
    // A character that causes no result leaves it untouched.
    b64d_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && (group.count != 2'd0)),
        .group        (group),
        .load_ready   (load_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// File: hdl/b64d_checker.sv
module b64d_checker
    import b64d_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result_item
);

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result withdrawn while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result_item))
        else $error("result changed while stalled");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.has_byte |->
            (result_item.message_done || result_item.bad_char))
        else $error("result with no byte, no end mark and no error");

    a_bad_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.bad_char |->
            (!result_item.has_byte && result_item.data_byte == 8'd0))
        else $error("error result carries a byte");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.has_byte |-> result_item.data_byte == 8'd0)
        else $error("data byte not zero without a byte");

endmodule

bind base64_stream_decoder_unit b64d_checker u_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import b64d_pkg::*;

    // One request for the text channel, with an optional typed-in expectation.
    // When typed is set, want holds the results exactly as they must appear;
    // otherwise the decoder model supplies them.
    typedef struct packed {
        in_item_t      item;
        logic          typed;
        result_group_t want;
    } text_request_t;

    localparam logic More  = 1'b0;
    localparam logic Last  = 1'b1;
    localparam logic Free  = 1'b0;
    localparam logic Typed = 1'b1;

    // Results that can be read off the behaviour at a glance.
    localparam out_item_t NoRes     = '0;
    localparam out_item_t EndEmpty  = {8'h00, 1'b0, 1'b1, 1'b0};
    localparam out_item_t ErrorMark = {8'h00, 1'b0, 1'b0, 1'b1};
    localparam out_item_t ErrorEnd  = {8'h00, 1'b0, 1'b1, 1'b1};
    localparam out_item_t ZeroByte  = {8'h00, 1'b1, 1'b0, 1'b0};
    localparam out_item_t OnesByte  = {8'hFF, 1'b1, 1'b0, 1'b0};
    localparam out_item_t OnesLast  = {8'hFF, 1'b1, 1'b1, 1'b0};

    localparam int DirRows = 26;

    // Directed requests: {character, end mark, typed, count, third, second, first}.
    localparam text_request_t DirTable [DirRows] = '{
        // A lone '=' straight after reset closes an empty message.
        {"=",   Last, Typed, 2'd1, NoRes,    NoRes,    EndEmpty},
        // NUL carrying the end mark: the error result is also the final one.
        {8'h00, Last, Typed, 2'd1, NoRes,    NoRes,    ErrorEnd},
        // The top byte value aborts the message; what follows is dropped.
        {8'hFF, More, Typed, 2'd1, NoRes,    NoRes,    ErrorMark},
        {"A",   More, Typed, 2'd0, NoRes,    NoRes,    NoRes},
        {"A",   Last, Typed, 2'd1, NoRes,    NoRes,    ErrorEnd},
        // Smallest and largest full groups.
        {"A",   More, Typed, 2'd0, NoRes,    NoRes,    NoRes},
        {"A",   More, Typed, 2'd0, NoRes,    NoRes,    NoRes},
        {"A",   More, Typed, 2'd0, NoRes,    NoRes,    NoRes},
        {"A",   More, Typed, 2'd3, ZeroByte, ZeroByte, ZeroByte},
        {"/",   More, Typed, 2'd0, NoRes,    NoRes,    NoRes},
        {"/",   More, Typed, 2'd0, NoRes,    NoRes,    NoRes},
        {"/",   More, Typed, 2'd0, NoRes,    NoRes,    NoRes},
        {"/",   Last, Typed, 2'd3, OnesLast, OnesByte, OnesByte},
        // A single sextet left at the end gives no byte.
        {"Q",   Last, Typed, 2'd1, NoRes,    NoRes,    EndEmpty},
        // Three sextets closed by a padding character.
        {"+",   More, Free,  2'd0, NoRes,    NoRes,    NoRes},
        {"9",   More, Free,  2'd0, NoRes,    NoRes,    NoRes},
        {"z",   More, Free,  2'd0, NoRes,    NoRes,    NoRes},
        {"=",   Last, Free,  2'd0, NoRes,    NoRes,    NoRes},
        // Two sextets, padding, then a bad character that must be ignored.
        {"T",   More, Free,  2'd0, NoRes,    NoRes,    NoRes},
        {"Q",   More, Free,  2'd0, NoRes,    NoRes,    NoRes},
        {"=",   More, Free,  2'd0, NoRes,    NoRes,    NoRes},
        {"*",   Last, Free,  2'd0, NoRes,    NoRes,    NoRes},
        // A bad character in the middle of a group throws the held sextets away.
        {"a",   More, Free,  2'd0, NoRes,    NoRes,    NoRes},
        {"0",   More, Free,  2'd0, NoRes,    NoRes,    NoRes},
        {"%",   More, Typed, 2'd1, NoRes,    NoRes,    ErrorMark},
        {"z",   Last, Typed, 2'd1, NoRes,    NoRes,    ErrorEnd}
    };

    logic      clk;
    logic      rst_n;
    logic      text_valid;
    logic      text_stall;
    in_item_t  text_item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result_item;

    // Decoder model state, mirrored from the block's behaviour.
    logic [17:0] sextet_acc;
    logic [1:0]  held_count;
    logic        pad_flag;
    logic        abort_flag;

    text_request_t text_requests[$];
    out_item_t     pending_results[$];
    int            fail_count = 0;

    base64_stream_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_item    (text_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Sextet value of a character of the standard alphabet, or -1 outside it.
    function automatic int sextet_lookup(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z")
        begin
            return int'(ch) - int'("A");
        end
        if (ch >= "a" && ch <= "z")
        begin
            return int'(ch) - int'("a") + 26;
        end
        if (ch >= "0" && ch <= "9")
        begin
            return int'(ch) - int'("0") + 52;
        end
        if (ch == "+")
        begin
            return 62;
        end
        if (ch == "/")
        begin
            return 63;
        end
        return -1;
    endfunction

    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        if (v < 26)
        begin
            return 8'("A") + 8'(v);
        end
        if (v < 52)
        begin
            return 8'("a") + 8'(v - 26);
        end
        if (v < 62)
        begin
            return 8'("0") + 8'(v - 52);
        end
        return (v == 62) ? 8'("+") : 8'("/");
    endfunction

    function automatic void clear_decoder();
        sextet_acc = '0;
        held_count = '0;
        pad_flag   = 1'b0;
        abort_flag = 1'b0;
    endfunction

    // Advances the model by one character and returns the results it causes.
    function automatic result_group_t decode_char(input in_item_t it);
        result_group_t g;
        int            v;
        int            n;
        logic [23:0]   grp;
        g = '0;
        n = 0;
        if (!abort_flag && !pad_flag)
        begin
            if (it.text_char == PadChar)
            begin
                pad_flag = 1'b1;
            end
            else
            begin
                v = sextet_lookup(it.text_char);
                if (v < 0)
                begin
                    // The error result doubles as the final one when the end mark rides on it.
                    abort_flag = 1'b1;
                    g.res[0] = {8'h00, 1'b0, it.end_of_text, 1'b1};
                    g.count = 2'd1;
                    if (it.end_of_text)
                    begin
                        clear_decoder();
                    end
                    return g;
                end
                if (held_count == 2'd3)
                begin
                    grp = {sextet_acc, 6'(v)};
                    g.res[0] = {grp[23:16], 1'b1, 1'b0, 1'b0};
                    g.res[1] = {grp[15:8], 1'b1, 1'b0, 1'b0};
                    g.res[2] = {grp[7:0], 1'b1, 1'b0, 1'b0};
                    n = 3;
                    sextet_acc = '0;
                    held_count = '0;
                end
                else
                begin
                    sextet_acc = {sextet_acc[11:0], 6'(v)};
                    held_count = held_count + 2'd1;
                end
            end
        end
        if (it.end_of_text)
        begin
            // Flush a partial group: n sextets give n-1 bytes.
            if (!abort_flag)
            begin
                if (held_count == 2'd3)
                begin
                    g.res[n] = {sextet_acc[17:10], 1'b1, 1'b0, 1'b0};
                    g.res[n + 1] = {sextet_acc[9:2], 1'b1, 1'b0, 1'b0};
                    n = n + 2;
                end
                else if (held_count == 2'd2)
                begin
                    g.res[n] = {sextet_acc[11:4], 1'b1, 1'b0, 1'b0};
                    n = n + 1;
                end
            end
            if (n > 0)
            begin
                g.res[n - 1].message_done = 1'b1;
            end
            else
            begin
                g.res[0] = {8'h00, 1'b0, 1'b1, abort_flag};
                n = 1;
            end
            clear_decoder();
        end
        g.count = 2'(n);
        return g;
    endfunction

    // Random idle gap before the next request or result, with calm stretches of none.
    function automatic int pick_gap(inout int calm);
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(10, 25);
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [7:0] pick_bad_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom);
        end
        while (sextet_lookup(c) >= 0 || c == PadChar);
        return c;
    endfunction

    // Queues a text of characters as one message, the end mark on its last one.
    function automatic int queue_text(ref logic [7:0] txt[$]);
        text_request_t r;
        for (int i = 0; i < txt.size(); i++)
        begin
            r = '0;
            r.item.text_char   = txt[i];
            r.item.end_of_text = (i == txt.size() - 1);
            text_requests.push_back(r);
        end
        return txt.size();
    endfunction

    // Encodes random bytes as base64; a broken message gets a bad character or
    // early padding with junk behind it.
    function automatic int queue_message(input bit broken);
        logic [7:0]  txt[$];
        logic [23:0] grp;
        int          nbytes;
        int          rem;
        int          pos;
        nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 9);
        for (int i = 0; i < nbytes; i += 3)
        begin
            grp = 24'($urandom);
            rem = (nbytes - i < 3) ? nbytes - i : 3;
            for (int j = 0; j <= rem; j++)
            begin
                txt.push_back(alphabet_char(grp[23 - 6 * j -: 6]));
            end
            if (rem < 3 && $urandom_range(0, 1) == 1)
            begin
                for (int j = rem; j < 3; j++)
                begin
                    txt.push_back(PadChar);
                end
            end
        end
        if (txt.size() == 0)
        begin
            txt.push_back(PadChar);
        end
        if (broken)
        begin
            pos = $urandom_range(0, txt.size() - 1);
            if ($urandom_range(0, 1) == 0)
            begin
                txt[pos] = pick_bad_char();
            end
            else
            begin
                txt.insert(pos, 8'($urandom));
                txt.insert(pos, PadChar);
            end
        end
        return queue_text(txt);
    endfunction

    function automatic int queue_noise();
        logic [7:0] txt[$];
        int         len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            txt.push_back(8'($urandom));
        end
        return queue_text(txt);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s, got %0h, expected %0h", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with nothing expected", got, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.data_byte !== want.data_byte)
        begin
            report_mismatch("data_byte", got.data_byte, want.data_byte);
        end
        if (got.has_byte !== want.has_byte)
        begin
            report_mismatch("has_byte", got.has_byte, want.has_byte);
        end
        if (got.message_done !== want.message_done)
        begin
            report_mismatch("message_done", got.message_done, want.message_done);
        end
        if (got.bad_char !== want.bad_char)
        begin
            report_mismatch("bad_char", got.bad_char, want.bad_char);
        end
    endtask

    // Stimulus: reset, the directed table, then random messages; each request
    // is offered after a random gap and held until the block takes it.
    initial
    begin : text_source
        text_request_t req;
        result_group_t got_group;
        int            gap;
        int            calm;
        int            random_count;
        rst_n      <= 1'b0;
        text_valid <= 1'b0;
        text_item  <= '0;
        clear_decoder();
        calm = 0;
        random_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DirRows; i++)
        begin
            text_requests.push_back(DirTable[i]);
        end
        while (random_count < 220)
        begin
            gap = $urandom_range(0, 19);
            if (gap < 14)
            begin
                random_count += queue_message(1'b0);
            end
            else if (gap < 17)
            begin
                random_count += queue_message(1'b1);
            end
            else
            begin
                random_count += queue_noise();
            end
        end

        while (text_requests.size() != 0)
        begin
            req = text_requests.pop_front();
            gap = pick_gap(calm);
            if (gap > 0)
            begin
                text_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            text_valid <= 1'b1;
            text_item  <= req.item;
            do
            begin
                @(posedge clk);
            end
            while (text_stall);
            // The model always advances, so typed rows keep it in step.
            got_group = decode_char(req.item);
            if (req.typed)
            begin
                got_group = req.want;
            end
            for (int k = 0; k < got_group.count; k++)
            begin
                pending_results.push_back(got_group.res[k]);
            end
        end
        text_valid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        // Let any stray result surface before the verdict.
        repeat (16) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** base64_stream_decoder_unit: PASSED **");
        end
        else
        begin
            $display("** base64_stream_decoder_unit: FAILED **");
        end
        $finish;
    end

    // Result side: random stalls, and one long hold-off so that the block backs
    // up and stalls its text input while the source keeps offering requests.
    initial
    begin : result_sink
        int pause;
        int calm;
        int taken;
        bit held_off;
        result_stall <= 1'b0;
        calm = 0;
        taken = 0;
        held_off = 1'b0;
        forever
        begin
            if (!held_off && taken == 30)
            begin
                held_off = 1'b1;
                pause = 80;
            end
            else
            begin
                pause = pick_gap(calm);
            end
            if (pause > 0)
            begin
                result_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!result_valid);
            taken = taken + 1;
            check_result(result_item);
        end
    end

    initial
    begin : watchdog
        #500000;
        $display("** base64_stream_decoder_unit: FAILED **");
        $finish;
    end

endmodule
